// ===== rtl/pwrf_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pwrf_pkg: shared types and constants of the pulse-width RF transmitter
// Frame layout, register indexes, reset values, queue item and status types.
// ============================================================================
package pwrf_pkg;

    localparam int unsigned PAYLOAD_WIDTH = 10;
    localparam int unsigned BIT_POS_W     = $clog2(PAYLOAD_WIDTH);
    localparam int unsigned TICK_W        = 16;
    localparam int unsigned PRE_W         = 6;
    localparam int unsigned CFG_IDX_W     = 2;

    localparam logic [2:0] CHK_SEED = 3'b101;

    localparam logic [TICK_W-1:0] SHORT_TICKS_RST = 16'd400;
    localparam logic [TICK_W-1:0] LONG_TICKS_RST  = 16'd1200;
    localparam logic [TICK_W-1:0] SYNC_TICKS_RST  = 16'd3000;
    localparam logic [PRE_W-1:0]  PREAMBLE_RST    = 6'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHORT_TICKS     = 2'd0,
        REG_LONG_TICKS      = 2'd1,
        REG_SYNC_LOW_TICKS  = 2'd2,
        REG_PREAMBLE_PULSES = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PRE  = 2'd1,
        PH_SYNC = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    // classified item as it travels through the queue
    typedef struct packed {
        logic                     is_start;
        logic [PAYLOAD_WIDTH-1:0] word;
    } item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

endpackage

// ===== rtl/pwrf_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pwrf_front: input classifier
// Sorts items into tick or start and builds the candidate frame word.
// ============================================================================
module pwrf_front (
    input  logic                                operation,
    input  logic [3:0]                          node_id,
    input  logic signed [7:0]                   direction,
    input  logic [1:0]                          sequence_req,
    output pwrf_pkg::item_t                     item
);

    logic       up;
    logic [2:0] chk;

    always_comb
    begin
        up  = (direction > 8'sd0);
        chk = node_id[2:0] ^ {1'b0, up, 1'b0} ^ {sequence_req[0], 2'b00}
              ^ pwrf_pkg::CHK_SEED;
        item.is_start = operation;
        item.word     = {node_id, up, sequence_req, chk};
    end

endmodule

// ===== rtl/pwrf_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pwrf_queue: two-entry item queue
// Decouples the classifier from the line sequencer; push and pop may coincide.
// ============================================================================
module pwrf_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pwrf_pkg::item_t       push_item,
    input  logic                  pop,
    output pwrf_pkg::item_t       head,
    output pwrf_pkg::q_status_t   status
);

    pwrf_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        head        = entry_reg[rd_ptr_reg];
        status.valid = (count_reg != 2'd0);
        status.full  = count_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/pwrf_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pwrf_back: line sequencer
// Holds the timing registers and frame state, runs one item per cycle unless
// the output stalls, and keeps the result in an output register.
// ============================================================================
module pwrf_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [pwrf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pwrf_pkg::TICK_W-1:0]            cfg_data,
    input  pwrf_pkg::q_status_t                    q_status,
    input  pwrf_pkg::item_t                        q_head,
    output logic                                   q_pop,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   line_level,
    output logic                                   busy_res,
    output logic                                   accepted,
    output logic                                   frame_done,
    output logic [pwrf_pkg::PAYLOAD_WIDTH-1:0]     frame_word
);

    localparam int unsigned TW = pwrf_pkg::TICK_W;
    localparam int unsigned PW = pwrf_pkg::PAYLOAD_WIDTH;
    localparam int unsigned BW = pwrf_pkg::BIT_POS_W;
    localparam int unsigned RW = pwrf_pkg::PRE_W;

    function automatic logic [TW-1:0] at_least_one(input logic [TW-1:0] v);
        return (v == '0) ? TW'(1) : v;
    endfunction

    logic [TW-1:0] short_reg, long_reg, sync_reg;
    logic [RW-1:0] pre_cfg_reg;

    pwrf_pkg::phase_t phase_reg, phase_next;
    logic             high_reg, high_next;
    logic [TW-1:0]    rem_reg, rem_next, rem_dec, lo_ticks;
    logic [RW-1:0]    pre_left_reg, pre_left_next, pre_dec;
    logic [BW-1:0]    bit_reg, bit_next;
    logic [PW-1:0]    word_reg, word_next;
    logic             acc_c, done_c, fire;

    logic             out_valid_reg, out_valid_next;
    logic             line_reg, busy_reg, acc_reg, done_reg;
    logic [PW-1:0]    fword_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg   <= pwrf_pkg::SHORT_TICKS_RST;
            long_reg    <= pwrf_pkg::LONG_TICKS_RST;
            sync_reg    <= pwrf_pkg::SYNC_TICKS_RST;
            pre_cfg_reg <= pwrf_pkg::PREAMBLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (pwrf_pkg::cfg_reg_t'(cfg_index))
                pwrf_pkg::REG_SHORT_TICKS:     short_reg   <= cfg_data;
                pwrf_pkg::REG_LONG_TICKS:      long_reg    <= cfg_data;
                pwrf_pkg::REG_SYNC_LOW_TICKS:  sync_reg    <= cfg_data;
                pwrf_pkg::REG_PREAMBLE_PULSES: pre_cfg_reg <= cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    assign fire  = q_status.valid && (!out_valid_reg || out_ready);
    assign q_pop = fire;

    always_comb
    begin
        phase_next    = phase_reg;
        high_next     = high_reg;
        rem_next      = rem_reg;
        pre_left_next = pre_left_reg;
        bit_next      = bit_reg;
        word_next     = word_reg;
        acc_c         = 1'b0;
        done_c        = 1'b0;
        rem_dec       = rem_reg - TW'(1);
        pre_dec       = pre_left_reg - RW'(1);

        // low duration chosen at the end of a high half
        priority if (phase_reg == pwrf_pkg::PH_SYNC)
            lo_ticks = sync_reg;
        else if (phase_reg == pwrf_pkg::PH_DATA && word_reg[bit_reg])
            lo_ticks = long_reg;
        else
            lo_ticks = short_reg;

        if (fire)
        begin
            if (q_head.is_start)
            begin
                if (phase_reg == pwrf_pkg::PH_IDLE)
                begin
                    word_next     = q_head.word;
                    pre_left_next = pre_cfg_reg;
                    phase_next    = (pre_cfg_reg != '0) ? pwrf_pkg::PH_PRE
                                                        : pwrf_pkg::PH_SYNC;
                    bit_next      = '0;
                    high_next     = 1'b1;
                    rem_next      = at_least_one(short_reg);
                    acc_c         = 1'b1;
                end
            end
            else if (phase_reg != pwrf_pkg::PH_IDLE)
            begin
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    priority if (high_reg)
                    begin
                        high_next = 1'b0;
                        rem_next  = at_least_one(lo_ticks);
                    end
                    else if (phase_reg == pwrf_pkg::PH_PRE)
                    begin
                        pre_left_next = pre_dec;
                        if (pre_dec == '0)
                            phase_next = pwrf_pkg::PH_SYNC;
                        high_next = 1'b1;
                        rem_next  = at_least_one(short_reg);
                    end
                    else if (phase_reg == pwrf_pkg::PH_SYNC)
                    begin
                        phase_next = pwrf_pkg::PH_DATA;
                        bit_next   = BW'(PW - 1);
                        high_next  = 1'b1;
                        rem_next   = at_least_one(short_reg);
                    end
                    else if (bit_reg == '0)
                    begin
                        phase_next = pwrf_pkg::PH_IDLE;
                        high_next  = 1'b0;
                        rem_next   = '0;
                        done_c     = 1'b1;
                    end
                    else
                    begin
                        bit_next  = bit_reg - BW'(1);
                        high_next = 1'b1;
                        rem_next  = at_least_one(short_reg);
                    end
                end
            end
        end

        out_valid_next = fire || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pwrf_pkg::PH_IDLE;
            high_reg      <= 1'b0;
            rem_reg       <= '0;
            pre_left_reg  <= '0;
            bit_reg       <= '0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            high_reg      <= high_next;
            rem_reg       <= rem_next;
            pre_left_reg  <= pre_left_next;
            bit_reg       <= bit_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register, loaded when an item is executed
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            line_reg  <= (phase_next != pwrf_pkg::PH_IDLE) && high_next;
            busy_reg  <= (phase_next != pwrf_pkg::PH_IDLE);
            acc_reg   <= acc_c;
            done_reg  <= done_c;
            fword_reg <= word_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_level = line_reg;
    assign busy_res   = busy_reg;
    assign accepted   = acc_reg;
    assign frame_done = done_reg;
    assign frame_word = fword_reg;

endmodule

// ===== rtl/pulse_width_rf_frame_transmitter.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pulse_width_rf_frame_transmitter: pulse-width OOK frame generator
// Builds a 10-bit frame word on start and times preamble, sync and data
// pulses on one line, one tick item at a time.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready): operation 0 is a tick, 1 a start with
//   node_id, direction and sequence_req. Every transfer yields exactly one
//   result on the output channel (out_valid/out_ready): line level after the
//   item, busy flag, start-taken flag, end-of-frame flag and the frame word.
//   Configuration: cfg_we writes cfg_data into the timing register selected by
//   cfg_index (0 short, 1 long, 2 sync low, 3 preamble count);
//   write only while no item is in flight.
//   Order: an input transfer is written into the queue, and the sequencer
//   then executes it from the queue head into the result register, which
//   raises out_valid until the result transfers.
//   Throughput: one item per clock while out_ready stays high; the sequencer
//   executes one item per cycle unless the output stalls, and the two-entry
//   queue plus the result register absorb the handshake turnaround.
//   Receiver stall: the result register holds, the queue fills, and in_ready
//   drops once both queue entries are taken; nothing is dropped.
//   Reset: timing registers return to 400/1200/3000/16, the sequencer is idle
//   with a zero frame word, both channels are empty; result fields are not reset.
// ============================================================================
module pulse_width_rf_frame_transmitter (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [pwrf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pwrf_pkg::TICK_W-1:0]            cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   operation,
    input  logic [3:0]                             node_id,
    input  logic signed [7:0]                      direction,
    input  logic [1:0]                             sequence_req,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   line_level,
    output logic                                   busy_res,
    output logic                                   accepted,
    output logic                                   frame_done,
    output logic [pwrf_pkg::PAYLOAD_WIDTH-1:0]     frame_word
);

    pwrf_pkg::item_t     front_item;
    pwrf_pkg::item_t     q_head;
    pwrf_pkg::q_status_t q_status;
    logic                q_push;
    logic                q_pop;

    // front: classify and form the candidate word
    pwrf_front u_front (
        .operation    (operation),
        .node_id      (node_id),
        .direction    (direction),
        .sequence_req (sequence_req),
        .item         (front_item)
    );

    // transfer into the queue whenever it has a free entry
    assign in_ready = !q_status.full;
    assign q_push   = in_valid && in_ready;

    pwrf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    // back: frame state, timing counters, result register
    pwrf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_status   (q_status),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .line_level (line_level),
        .busy_res   (busy_res),
        .accepted   (accepted),
        .frame_done (frame_done),
        .frame_word (frame_word)
    );

`ifndef ASSERT_OFF
    // a start that was taken leaves the line high and the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> busy_res && line_level)
        else $error("accepted start without busy high line");

    // an idle line is low, and frame end always leaves the block idle
    a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (!busy_res || frame_done) |-> !line_level && !busy_res)
        else $error("line high while idle");

    // the queue never pops while empty
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_status.valid)
        else $error("queue popped while empty");

    // a full queue with a stalled receiver stays full
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full && out_valid && !out_ready |=> q_status.full)
        else $error("queue lost an entry during a stall");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for pulse_width_rf_frame_transmitter
// Drives tick and start items through the valid/ready input channel, keeps
// its own line-timing model of the transmitter, and compares every result
// transfer field by field. Timing registers are rewritten between sessions.
// ============================================================================
module testbench;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned IDLE_PCT    = 32;
    localparam int unsigned PIPE_CYCLES = 4;
    localparam int unsigned TW          = pwrf_pkg::TICK_W;

    // one input item as queued for the driver
    typedef struct packed {
        logic       op;
        logic [3:0] node;
        logic [7:0] dir;
        logic [1:0] seq;
    } tx_item_t;

    // one result transfer
    typedef struct packed {
        logic                               line;
        logic                               busy;
        logic                               acc;
        logic                               done;
        logic [pwrf_pkg::PAYLOAD_WIDTH-1:0] word;
    } line_result_t;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           cfg_we       = 1'b0;
    logic [pwrf_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic [TW-1:0]                  cfg_data     = '0;
    logic                           in_valid     = 1'b0;
    logic                           operation    = 1'b0;
    logic [3:0]                     node_id      = '0;
    logic signed [7:0]              direction    = '0;
    logic [1:0]                     sequence_req = '0;
    logic                           out_ready    = 1'b0;
    logic                           in_ready;
    logic                           out_valid;
    logic                           line_level;
    logic                           busy_res;
    logic                           accepted;
    logic                           frame_done;
    logic [pwrf_pkg::PAYLOAD_WIDTH-1:0] frame_word;

    tx_item_t     tx_items[$];      // items waiting to be presented
    line_result_t line_expect[$];   // predicted results, oldest first
    int unsigned  errors      = 0;
    int unsigned  cycle_count = 0;
    bit           steady_flow = 1'b0;   // suppresses idling on both sides

    // model copy of the timing registers
    logic [TW-1:0]              t_short = pwrf_pkg::SHORT_TICKS_RST;
    logic [TW-1:0]              t_long  = pwrf_pkg::LONG_TICKS_RST;
    logic [TW-1:0]              t_sync  = pwrf_pkg::SYNC_TICKS_RST;
    logic [pwrf_pkg::PRE_W-1:0] n_pre   = pwrf_pkg::PREAMBLE_RST;

    // model copy of the line sequencer
    pwrf_pkg::phase_t                   m_phase  = pwrf_pkg::PH_IDLE;
    logic                               m_high   = 1'b0;
    logic [TW-1:0]                      m_remain = '0;
    logic [pwrf_pkg::PRE_W-1:0]         m_pre    = '0;
    logic [3:0]                         m_bitpos = '0;
    logic [pwrf_pkg::PAYLOAD_WIDTH-1:0] m_word   = '0;

    pulse_width_rf_frame_transmitter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .node_id      (node_id),
        .direction    (direction),
        .sequence_req (sequence_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .line_level   (line_level),
        .busy_res     (busy_res),
        .accepted     (accepted),
        .frame_done   (frame_done),
        .frame_word   (frame_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // zero-length durations count as one tick
    function automatic logic [TW-1:0] at_least_one(input logic [TW-1:0] v);
        return (v == '0) ? TW'(1) : v;
    endfunction

    // Next half-pulse once the running duration has expired.
    // Returns 1 when the last data low ends the frame.
    function automatic logic next_half();
        logic [TW-1:0] low_len;
        if (m_high)
        begin
            low_len = t_short;
            if (m_phase == pwrf_pkg::PH_SYNC)
                low_len = t_sync;
            else if (m_phase == pwrf_pkg::PH_DATA && m_word[m_bitpos])
                low_len = t_long;
            m_high   = 1'b0;
            m_remain = at_least_one(low_len);
            return 1'b0;
        end
        if (m_phase == pwrf_pkg::PH_PRE)
        begin
            m_pre = m_pre - 1'b1;
            if (m_pre == '0)
                m_phase = pwrf_pkg::PH_SYNC;
        end
        else if (m_phase == pwrf_pkg::PH_SYNC)
        begin
            m_phase  = pwrf_pkg::PH_DATA;
            m_bitpos = 4'(pwrf_pkg::PAYLOAD_WIDTH - 1);
        end
        else if (m_bitpos == '0)
        begin
            // last data pulse done: line drops, sequencer goes idle
            m_phase  = pwrf_pkg::PH_IDLE;
            m_high   = 1'b0;
            m_remain = '0;
            return 1'b1;
        end
        else
            m_bitpos = m_bitpos - 1'b1;
        m_high   = 1'b1;
        m_remain = at_least_one(t_short);
        return 1'b0;
    endfunction

    // Work out the line result of one accepted item and queue it.
    function automatic void predict_line(input tx_item_t it);
        line_result_t r;
        logic         up;
        logic [2:0]   chk;
        r = '0;
        if (it.op)
        begin
            // a start while a frame is running is dropped silently
            if (m_phase == pwrf_pkg::PH_IDLE)
            begin
                up       = ($signed(it.dir) > 0);
                chk      = it.node[2:0] ^ {1'b0, up, 1'b0} ^ {it.seq[0], 2'b00}
                           ^ pwrf_pkg::CHK_SEED;
                m_word   = {it.node, up, it.seq, chk};
                m_pre    = n_pre;
                m_phase  = (n_pre != '0) ? pwrf_pkg::PH_PRE : pwrf_pkg::PH_SYNC;
                m_bitpos = '0;
                m_high   = 1'b1;
                m_remain = at_least_one(t_short);
                r.acc    = 1'b1;
            end
        end
        else if (m_phase != pwrf_pkg::PH_IDLE)
        begin
            m_remain = m_remain - 1'b1;
            if (m_remain == '0)
                r.done = next_half();
        end
        r.busy = (m_phase != pwrf_pkg::PH_IDLE);
        r.line = r.busy ? m_high : 1'b0;
        r.word = m_word;
        line_expect.push_back(r);
    endfunction

    // Input driver: holds valid and payload until the transfer, idles at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            operation    <= 1'b0;
            node_id      <= '0;
            direction    <= '0;
            sequence_req <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_line({operation, node_id, direction, sequence_req});
            if (!in_valid || in_ready)
            begin
                if (tx_items.size() != 0
                    && (steady_flow || $urandom_range(99) >= IDLE_PCT))
                begin
                    tx_item_t it;
                    it = tx_items.pop_front();
                    in_valid     <= 1'b1;
                    operation    <= it.op;
                    node_id      <= it.node;
                    direction    <= it.dir;
                    sequence_req <= it.seq;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endfunction

    // Result monitor: stalls at random and checks each transfer in order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (line_expect.size() == 0)
                begin
                    errors++;
                    $display("%0t: result transfer with nothing expected, expected none, got %0d",
                             $time, {line_level, busy_res, accepted, frame_done, frame_word});
                end
                else
                begin
                    line_result_t e;
                    e = line_expect.pop_front();
                    check_field("line_level", e.line, line_level);
                    check_field("busy_res",   e.busy, busy_res);
                    check_field("accepted",   e.acc,  accepted);
                    check_field("frame_done", e.done, frame_done);
                    check_field("frame_word", e.word, frame_word);
                end
            end
            out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Run limit: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_item(input logic op, input logic [3:0] node,
                              input logic [7:0] dir, input logic [1:0] seq);
        tx_items.push_back('{op, node, dir, seq});
    endtask

    // direction leans on the sign boundary: 0, +1, -1, +127, -128
    function automatic logic [7:0] pick_direction();
        unique case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'hFF;
            3: return 8'h7F;
            4: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    // ticks carry random don't-care fields so every input bit toggles
    task automatic queue_ticks(input int unsigned n);
        repeat (n)
            queue_item(1'b0, 4'($urandom), 8'($urandom), 2'($urandom));
    endtask

    task automatic queue_random(input int unsigned n, input int unsigned start_pct);
        repeat (n)
            queue_item($urandom_range(99) < start_pct, 4'($urandom), pick_direction(),
                       2'($urandom));
    endtask

    // wait for every item to transfer and every result to come back
    task automatic settle();
        while (tx_items.size() != 0 || in_valid || line_expect.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input pwrf_pkg::cfg_reg_t idx, input logic [TW-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        unique case (idx)
            pwrf_pkg::REG_SHORT_TICKS:     t_short = v;
            pwrf_pkg::REG_LONG_TICKS:      t_long  = v;
            pwrf_pkg::REG_SYNC_LOW_TICKS:  t_sync  = v;
            pwrf_pkg::REG_PREAMBLE_PULSES: n_pre   = v[pwrf_pkg::PRE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_timing(input logic [TW-1:0] s, input logic [TW-1:0] l,
                                input logic [TW-1:0] sy, input logic [TW-1:0] p);
        write_reg(pwrf_pkg::REG_SHORT_TICKS, s);
        write_reg(pwrf_pkg::REG_LONG_TICKS, l);
        write_reg(pwrf_pkg::REG_SYNC_LOW_TICKS, sy);
        write_reg(pwrf_pkg::REG_PREAMBLE_PULSES, p);
    endtask

    // One random session: new timing, then mostly ticks with occasional starts.
    // Halfway the sender holds off until the pipeline is empty.
    task automatic run_session(input logic [TW-1:0] s, input logic [TW-1:0] l,
                               input logic [TW-1:0] sy, input logic [TW-1:0] p,
                               input int unsigned n, input bit quiet);
        settle();
        write_timing(s, l, sy, p);
        steady_flow = quiet;
        queue_random(n / 2, 8);
        settle();
        queue_random(n - n / 2, 8);
        settle();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset timing: idle ticks, a frame start, a start while busy,
        // then one full short high and the first preamble low
        queue_item(1'b0, 4'hF, 8'hFF, 2'd3);
        queue_item(1'b0, 4'h0, 8'h00, 2'd0);
        queue_item(1'b1, 4'hF, 8'h7F, 2'd3);
        queue_item(1'b1, 4'h0, 8'h80, 2'd0);
        queue_ticks(400);
        settle();

        // minimum timing: the pending 400-tick low runs out, frame finishes
        write_timing(16'd1, 16'd1, 16'd1, 16'd1);
        queue_ticks(470);
        queue_item(1'b1, 4'hA, 8'h01, 2'd2);
        queue_item(1'b1, 4'h5, 8'hFF, 2'd1);
        queue_ticks(30);
        settle();

        // zero durations act as one tick; zero preamble starts at sync
        write_timing(16'd0, 16'd0, 16'd0, 16'd0);
        queue_item(1'b1, 4'h5, 8'h00, 2'd1);
        queue_ticks(25);
        queue_item(1'b1, 4'h0, 8'h80, 2'd0);
        queue_ticks(25);
        queue_item(1'b1, 4'hF, 8'h7F, 2'd3);
        queue_ticks(25);
        settle();

        // random sessions; the preamble write with high bits set keeps only [5:0]
        run_session(16'd2, 16'd5, 16'd7, 16'hFFC3, 50, 1'b0);
        run_session(16'd1, 16'd3, 16'd2, 16'd0, 100, 1'b1);
        repeat (4)
            run_session(16'($urandom_range(3)), 16'($urandom_range(6)),
                        16'($urandom_range(8)), 16'($urandom_range(5)), 20, 1'b0);
        run_session(16'd3, 16'd1, 16'd1, 16'd2, 30, 1'b0);

        // largest settings: a frame starts and barely moves
        run_session(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20, 1'b0);

        repeat (PIPE_CYCLES * 2) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
